[src/pid_dom_antiwindup_core_macros.svh]
// Assertion macros shared by the checker of the PID controller core.
// Every macro expects aclk to be visible where it is used, and PDA_ASSERT also aresetn.
`ifndef PID_DOM_ANTIWINDUP_CORE_MACROS_SVH
`define PID_DOM_ANTIWINDUP_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PDA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked assertion that also holds while reset is held.
`define PDA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/pid_dom_pkg.sv]
// Shared types, widths and helpers of the PID controller core.
// No dependencies; every other RTL file imports this package.
package pid_dom_pkg;

    localparam int ValW  = 16;           // measurement, gains, limits, drive
    localparam int ErrW  = ValW + 1;     // difference of two values
    localparam int ProdW = ValW + ErrW;  // gain times difference
    localparam int AccW  = 40;           // saturating integral
    localparam int SumW  = AccW + 4;     // headroom for sums and corrections
    localparam int FracW = 8;            // fraction bits of gains and sums
    localparam int IdxW  = 3;

    localparam logic [IdxW-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [IdxW-1:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [IdxW-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [IdxW-1:0] REG_TARGET        = 3'd3;
    localparam logic [IdxW-1:0] REG_DRIVE_LOW     = 3'd4;
    localparam logic [IdxW-1:0] REG_DRIVE_HIGH    = 3'd5;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } clamp_t;

    typedef struct packed {
        logic signed [ValW-1:0] prop_gain;
        logic signed [ValW-1:0] integral_gain;
        logic signed [ValW-1:0] deriv_gain;
        logic signed [ValW-1:0] target;
        logic signed [ValW-1:0] drive_low;
        logic signed [ValW-1:0] drive_high;
    } cfg_t;

    // Products handed from the multiply stage to the accumulate stage.
    typedef struct packed {
        logic                    valid;
        logic signed [ProdW-1:0] p_term;
        logic signed [ProdW-1:0] i_term;
        logic signed [ProdW-1:0] d_term;
    } prod_t;

    function automatic logic signed [AccW-1:0] sat_acc(input logic signed [SumW-1:0] v);
        logic signed [SumW-1:0] acc_max;
        logic signed [SumW-1:0] acc_min;
        acc_max = SumW'({1'b0, {(AccW-1){1'b1}}});
        acc_min = -acc_max - SumW'(1);
        if (v > acc_max) begin
            sat_acc = acc_max[AccW-1:0];
        end else if (v < acc_min) begin
            sat_acc = acc_min[AccW-1:0];
        end else begin
            sat_acc = v[AccW-1:0];
        end
    endfunction

endpackage

[src/pid_dom_cfg.sv]
// Configuration register file of the PID controller core.
// Depends on pid_dom_pkg.
module pid_dom_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pid_dom_pkg::IdxW-1:0] cfg_index,
    input  logic [pid_dom_pkg::ValW-1:0] cfg_data,
    output pid_dom_pkg::cfg_t          cfg
);
    import pid_dom_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROP_GAIN:     cfg_next.prop_gain     = cfg_data;
                REG_INTEGRAL_GAIN: cfg_next.integral_gain = cfg_data;
                REG_DERIV_GAIN:    cfg_next.deriv_gain    = cfg_data;
                REG_TARGET:        cfg_next.target        = cfg_data;
                REG_DRIVE_LOW:     cfg_next.drive_low     = cfg_data;
                REG_DRIVE_HIGH:    cfg_next.drive_high    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain     <= ValW'(256);
            cfg_reg.integral_gain <= '0;
            cfg_reg.deriv_gain    <= '0;
            cfg_reg.target        <= '0;
            cfg_reg.drive_low     <= {1'b1, {(ValW-1){1'b0}}};
            cfg_reg.drive_high    <= {1'b0, {(ValW-1){1'b1}}};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/pid_dom_prod.sv]
// Input stage of the PID controller core: error, measurement step and the
// three gain products, registered. Depends on pid_dom_pkg.
module pid_dom_prod (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pid_dom_pkg::cfg_t            cfg,
    input  logic                         in_take,
    input  logic                         advance,
    input  logic [pid_dom_pkg::ValW-1:0] meas,
    output pid_dom_pkg::prod_t           prod
);
    import pid_dom_pkg::*;

    logic signed [ValW-1:0]  last_meas_reg;
    logic signed [ValW-1:0]  last_meas_next;
    prod_t                   prod_reg;
    prod_t                   prod_next;
    logic signed [ErrW-1:0]  err;
    logic signed [ErrW-1:0]  step;

    assign err  = ErrW'(cfg.target) - ErrW'($signed(meas));
    assign step = ErrW'($signed(meas)) - ErrW'(last_meas_reg);

    always_comb begin
        prod_next      = prod_reg;
        last_meas_next = last_meas_reg;
        if (advance) begin
            prod_next.valid = in_take;
        end
        if (in_take) begin
            prod_next.p_term = ProdW'(cfg.prop_gain) * ProdW'(err);
            prod_next.i_term = ProdW'(cfg.integral_gain) * ProdW'(err);
            prod_next.d_term = ProdW'(cfg.deriv_gain) * ProdW'(step);
            last_meas_next   = $signed(meas);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg.valid <= 1'b0;
            last_meas_reg  <= '0;
        end else begin
            prod_reg.valid <= prod_next.valid;
            last_meas_reg  <= last_meas_next;
        end
        prod_reg.p_term <= prod_next.p_term;
        prod_reg.i_term <= prod_next.i_term;
        prod_reg.d_term <= prod_next.d_term;
    end

    assign prod = prod_reg;

endmodule

[src/pid_dom_acc.sv]
// Accumulate stage of the PID controller core: integral update, clamp,
// anti-windup correction and the result register. Depends on pid_dom_pkg.
module pid_dom_acc (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pid_dom_pkg::cfg_t            cfg,
    input  pid_dom_pkg::prod_t           prod,
    output logic                         advance,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pid_dom_pkg::ValW-1:0] drive,
    output pid_dom_pkg::clamp_t          clamp_state
);
    import pid_dom_pkg::*;

    logic signed [AccW-1:0] integral_acc_reg;
    logic signed [AccW-1:0] integral_acc_next;
    logic                   first_pending_reg;
    logic                   first_pending_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [ValW-1:0]        drive_reg;
    logic [ValW-1:0]        drive_next;
    clamp_t                 clamp_reg;
    clamp_t                 clamp_next;

    logic                   work;
    logic signed [AccW-1:0] acc_upd;
    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    logic signed [SumW-1:0] clamped;
    logic signed [AccW-1:0] acc_fixed;

    // The output register moves whenever it is empty or being emptied.
    assign advance = !m_valid_reg || m_tready;
    assign work    = advance && prod.valid;

    assign hi = SumW'(cfg.drive_high) <<< FracW;
    assign lo = SumW'(cfg.drive_low) <<< FracW;

    always_comb begin
        // The first sample after reset starts from a zero integral and a zero sum.
        if (first_pending_reg) begin
            acc_upd = '0;
            sum     = '0;
        end else begin
            acc_upd = sat_acc(SumW'(integral_acc_reg) + SumW'(prod.i_term));
            sum     = SumW'(prod.p_term) + SumW'(acc_upd) - SumW'(prod.d_term);
        end
        // High limit is tested first; with inverted limits, sums above it clamp high, all others low.
        if (sum > hi) begin
            acc_fixed  = sat_acc(SumW'(acc_upd) - (sum - hi));
            clamped    = hi;
            clamp_next = CLAMP_HIGH;
        end else if (sum < lo) begin
            acc_fixed  = sat_acc(SumW'(acc_upd) + (lo - sum));
            clamped    = lo;
            clamp_next = CLAMP_LOW;
        end else begin
            acc_fixed  = acc_upd;
            clamped    = sum;
            clamp_next = CLAMP_NONE;
        end
        drive_next = clamped[FracW +: ValW];
    end

    always_comb begin
        integral_acc_next  = integral_acc_reg;
        first_pending_next = first_pending_reg;
        m_valid_next       = m_valid_reg;
        if (advance) begin
            m_valid_next = prod.valid;
        end
        if (work) begin
            integral_acc_next  = acc_fixed;
            first_pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_acc_reg  <= '0;
            first_pending_reg <= 1'b1;
            m_valid_reg       <= 1'b0;
        end else begin
            integral_acc_reg  <= integral_acc_next;
            first_pending_reg <= first_pending_next;
            m_valid_reg       <= m_valid_next;
        end
        if (work) begin
            drive_reg <= drive_next;
            clamp_reg <= clamp_next;
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign drive       = drive_reg;
    assign clamp_state = clamp_reg;

endmodule

[src/pid_dom_antiwindup_core.sv]
// PID controller core with derivative on measurement and integral anti-windup.
// Depends on pid_dom_pkg, pid_dom_cfg, pid_dom_prod and pid_dom_acc.
//
// Usage:
// The s_ channel takes one signed 16-bit measurement per sample in s_tdata.
// The m_ channel returns one result per measurement: the clamped drive value
// in m_tdata and the clamp state in m_tuser (none, high or low).
// The cfg_ channel writes the six control registers by index (gains, target,
// output limits). It is always ready, and it should be written only while no
// sample is in flight.
// An input transfer is registered first in the multiply stage (three 16 by 17
// bit products) and then in the accumulate stage (integral update, clamp and
// anti-windup), whose result register drives m_tvalid.
// Throughput is one sample per cycle unless the receiver stalls; the integral loop
// closes within the accumulate stage, so back-to-back samples are handled without bubbles.
// Synchronous reset, active low, restores the register defaults, clears the
// integral and the pipeline, and arms the first-sample rule: the first sample
// after reset outputs the clamped zero sum, records its measurement and takes the clamp correction as its integral.
// When the receiver stalls, the result is held and s_tready drops at once,
// so the whole pipeline freezes with no sample lost or repeated.
module pid_dom_antiwindup_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Measurement input.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pid_dom_pkg::ValW-1:0]   s_tdata,   // [15:0] measurement
    // Result output.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pid_dom_pkg::ValW-1:0]   m_tdata,   // [15:0] drive
    output logic [1:0]                     m_tuser,   // [1:0] clamp_state
    // Configuration writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pid_dom_pkg::IdxW-1:0]   cfg_index,
    input  logic [pid_dom_pkg::ValW-1:0]   cfg_data
);
    import pid_dom_pkg::*;

    cfg_t   cfg;
    prod_t  prod;
    clamp_t clamp_state;
    logic   advance;
    logic   in_take;

    // The input stage moves together with the output register.
    assign s_tready = advance;
    assign in_take  = s_tvalid && advance;

    pid_dom_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pid_dom_prod u_prod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .in_take (in_take),
        .advance (advance),
        .meas    (s_tdata),
        .prod    (prod)
    );

    pid_dom_acc u_acc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .prod        (prod),
        .advance     (advance),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .drive       (m_tdata),
        .clamp_state (clamp_state)
    );

    assign m_tuser = clamp_state;

endmodule

[src/pid_dom_chk.sv]
// Port-level checker of the PID controller core, bound to the top level.
// Depends on pid_dom_pkg and pid_dom_antiwindup_core_macros.svh.
`include "pid_dom_antiwindup_core_macros.svh"

module pid_dom_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pid_dom_pkg::ValW-1:0] m_tdata,
    input logic [1:0]                   m_tuser
);
    import pid_dom_pkg::*;

    // A stalled result keeps its value.
    `PDA_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // The clamp state never takes the unused code.
    `PDA_ASSERT(a_clamp_code, m_tvalid |-> (m_tuser == CLAMP_NONE || m_tuser == CLAMP_HIGH || m_tuser == CLAMP_LOW), "bad clamp state")

    // A new result appears only after an input transfer has passed the product register.
    `PDA_ASSERT(a_latency, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result without matching input")

    // Reset empties the result register.
    `PDA_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind pid_dom_antiwindup_core pid_dom_chk u_chk (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of pid_dom_antiwindup_core: a cycle-free predictor of the PID
// drive and clamp state, fed from the observed transfers. Depends on pid_dom_pkg and the core.
module tb;
    import pid_dom_pkg::*;

    // Register indexes that the core does not map; writes to them must change nothing.
    localparam logic [IdxW-1:0] REG_UNMAPPED_A = 3'd6;
    localparam logic [IdxW-1:0] REG_UNMAPPED_B = 3'd7;

    // Field extremes used by the directed part, in the order they are sent.
    localparam logic [ValW-1:0] EDGE_MEAS [6] = '{16'h0000, 16'h7FFF, 16'h8000,
                                                  16'hFFFF, 16'h0001, 16'h8000};

    typedef struct packed {
        logic [ValW-1:0] drive;
        clamp_t          clamp;
    } drive_result_t;

    typedef struct packed {
        logic signed [ValW-1:0] prop;
        logic signed [ValW-1:0] integ;
        logic signed [ValW-1:0] deriv;
        logic signed [ValW-1:0] target;
        logic signed [ValW-1:0] out_low;
        logic signed [ValW-1:0] out_high;
    } settings_t;

    // Predicts one drive value per accepted measurement and checks the results in order.
    class pid_drive_checker;
        logic signed [ValW-1:0] prop_gain, integ_gain, deriv_gain;
        logic signed [ValW-1:0] setpoint, out_low, out_high;
        longint         integ_acc, prev_meas, prev_sum;
        bit             first_sample;
        drive_result_t  expected_drives[$];
        int             checked, mismatches;
        int             clamp_seen[3];

        function new();
            prop_gain    = 16'sd256;
            integ_gain   = '0;
            deriv_gain   = '0;
            setpoint     = '0;
            out_low      = 16'sh8000;
            out_high     = 16'sh7FFF;
            integ_acc    = 0;
            prev_meas    = 0;
            prev_sum     = 0;
            first_sample = 1'b1;
            checked      = 0;
            mismatches   = 0;
            clamp_seen   = '{0, 0, 0};
        endfunction

        function void write_register(logic [IdxW-1:0] idx, logic [ValW-1:0] value);
            case (idx)
                REG_PROP_GAIN:     prop_gain  = value;
                REG_INTEGRAL_GAIN: integ_gain = value;
                REG_DERIV_GAIN:    deriv_gain = value;
                REG_TARGET:        setpoint   = value;
                REG_DRIVE_LOW:     out_low    = value;
                REG_DRIVE_HIGH:    out_high   = value;
                default: ;
            endcase
        endfunction

        function longint clip_integral(longint v);
            longint top;
            top = (64'sd1 <<< (AccW - 1)) - 1;
            if (v > top) return top;
            if (v < -top - 1) return -top - 1;
            return v;
        endfunction

        function void predict_drive(logic [ValW-1:0] raw);
            longint        meas, err, sum, ceil_hi, floor_lo;
            drive_result_t r;
            meas     = longint'($signed(raw));
            err      = longint'(setpoint) - meas;
            ceil_hi  = longint'(out_high) * 256;
            floor_lo = longint'(out_low) * 256;
            if (first_sample) begin
                // The first sample only re-clamps the previous sum and clears the integral.
                first_sample = 1'b0;
                integ_acc    = 0;
                sum          = prev_sum;
            end else begin
                integ_acc = clip_integral(integ_acc + longint'(integ_gain) * err);
                sum = longint'(prop_gain) * err + integ_acc
                    - longint'(deriv_gain) * (meas - prev_meas);
            end
            r.clamp = CLAMP_NONE;
            if (sum > ceil_hi) begin
                integ_acc = clip_integral(integ_acc - (sum - ceil_hi));
                sum       = ceil_hi;
                r.clamp   = CLAMP_HIGH;
            end else if (sum < floor_lo) begin
                integ_acc = clip_integral(integ_acc + (floor_lo - sum));
                sum       = floor_lo;
                r.clamp   = CLAMP_LOW;
            end
            prev_sum  = sum;
            prev_meas = meas;
            r.drive   = ValW'(sum >>> FracW);
            expected_drives.push_back(r);
        endfunction

        function void check_drive(logic [ValW-1:0] drive, logic [1:0] clamp);
            drive_result_t want;
            if (expected_drives.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual drive %0d clamp %0d",
                         $time, $signed(drive), clamp);
                mismatches++;
                return;
            end
            want = expected_drives.pop_front();
            checked++;
            clamp_seen[int'(want.clamp)]++;
            if (drive !== want.drive) begin
                $display("%0t: drive mismatch, expected %0d, actual %0d",
                         $time, $signed(want.drive), $signed(drive));
                mismatches++;
            end
            if (clamp !== want.clamp) begin
                $display("%0t: clamp_state mismatch, expected %0d, actual %0d",
                         $time, want.clamp, clamp);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            s_tvalid  = 1'b0;
    logic            s_tready;
    logic [ValW-1:0] s_tdata   = '0;
    logic            m_tvalid;
    logic            m_tready  = 1'b0;
    logic [ValW-1:0] m_tdata;
    logic [1:0]      m_tuser;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [IdxW-1:0] cfg_index = '0;
    logic [ValW-1:0] cfg_data  = '0;

    // Idle mix of the current phase, in percent per cycle, and a pending output hold-off.
    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_cycles = 0;

    // Target of the active settings; random measurements cluster around it.
    logic signed [ValW-1:0] set_target = '0;
    int settings_applied = 0;

    pid_drive_checker tracker;

    pid_dom_antiwindup_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] measurement
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [15:0] drive
        .m_tuser   (m_tuser),    // [1:0] clamp_state
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Monitor. It runs at the rising edge and reads the values that held just before it,
    // since every input is driven with nonblocking assignments. The result is checked before
    // the new measurement is noted; a result can never belong to an input of the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tracker.check_drive(m_tdata, m_tuser);
            end
            if (s_tvalid && s_tready) begin
                tracker.predict_drive(s_tdata);
            end
            if (cfg_valid && cfg_ready) begin
                tracker.write_register(cfg_index, cfg_data);
            end
        end
    end

    // Result receiver. A requested hold-off is counted here, in cycles, so that the sender
    // keeps offering measurements while the output is blocked and the pipeline backs up.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && hold_cycles > 0) begin
                hold_left   = hold_cycles;
                hold_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offers one measurement, after a random gap, and returns at the edge of its transfer.
    // s_tvalid is only lowered when a gap follows, so it never gets two updates in one step.
    task automatic send_measurement(input logic [ValW-1:0] value);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < gap_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Offers one register write and returns at the edge of its transfer. The caller lowers
    // cfg_valid after the last write of a batch.
    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [ValW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Holds the input low until every expected drive value has been received.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    // Writes all six registers, now and then with an unmapped index mixed in.
    task automatic apply_settings(input settings_t cfg);
        write_reg(REG_PROP_GAIN, cfg.prop);
        write_reg(REG_INTEGRAL_GAIN, cfg.integ);
        write_reg(REG_DERIV_GAIN, cfg.deriv);
        if ($urandom_range(1) == 0) begin
            write_reg($urandom_range(1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, 16'($urandom));
        end
        write_reg(REG_TARGET, cfg.target);
        write_reg(REG_DRIVE_LOW, cfg.out_low);
        write_reg(REG_DRIVE_HIGH, cfg.out_high);
        cfg_valid  <= 1'b0;
        set_target  = cfg.target;
        settings_applied++;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 51; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 51; end
            default: begin gap_pct = 29; stall_pct = 29; end
        endcase
    endtask

    // Mostly small values so that the loop settles inside its limits; sometimes any value.
    function automatic logic [ValW-1:0] small_or_full(input int span);
        if ($urandom_range(5) == 0) return ValW'($urandom);
        return ValW'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic settings_t random_settings();
        settings_t s;
        int        a, b;
        s.prop   = small_or_full(512);
        s.integ  = small_or_full(48);
        s.deriv  = small_or_full(256);
        s.target = small_or_full(2000);
        a = int'($urandom_range(16000)) - 8000;
        b = int'($urandom_range(16000)) - 8000;
        case ($urandom_range(7))
            0: begin s.out_low = 16'sh8000;       s.out_high = 16'sh7FFF;       end
            1: begin s.out_low = ValW'(a);        s.out_high = ValW'(a);        end
            2: begin s.out_low = ValW'(a > b ? a : b); s.out_high = ValW'(a > b ? b : a); end
            default: begin
                s.out_low  = ValW'(a < b ? a : b);
                s.out_high = ValW'(a < b ? b : a);
            end
        endcase
        return s;
    endfunction

    // Most measurements follow a slow walk near the target, which keeps the controller in its
    // linear range; the rest are extremes and arbitrary values that drive it into the clamps.
    function automatic logic [ValW-1:0] pick_measurement(input logic [ValW-1:0] recent);
        case ($urandom_range(9))
            0:       return EDGE_MEAS[$urandom_range(5)];
            1, 2:    return ValW'($urandom);
            3:       return ValW'(int'(set_target) + int'($urandom_range(128)) - 64);
            default: return ValW'(int'($signed(recent)) + int'($urandom_range(32)) - 16);
        endcase
    endfunction

    initial begin
        settings_t       cfg;
        logic [ValW-1:0] walk;
        int              errors;
        tracker = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Only the lower limit is raised before the first sample, so the
        // first-sample rule has to clamp the held zero sum and feed the cut into the integral.
        write_reg(REG_DRIVE_LOW, 16'sd7);
        write_reg(REG_UNMAPPED_A, 16'hA5C3);
        write_reg(REG_UNMAPPED_B, 16'h5A3C);
        cfg_valid <= 1'b0;
        foreach (EDGE_MEAS[k]) send_measurement(EDGE_MEAS[k]);
        drain_results();

        // Gains and target at opposite extremes, full output range.
        apply_settings('{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
        foreach (EDGE_MEAS[k]) send_measurement(EDGE_MEAS[k]);
        drain_results();
        apply_settings('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF});
        foreach (EDGE_MEAS[k]) send_measurement(EDGE_MEAS[k]);
        drain_results();

        // Inverted limits: the high test wins, and no sum can stay unclamped.
        apply_settings('{16'sd256, 16'sd32, 16'sd128, 16'sd0, 16'sd100, -16'sd100});
        foreach (EDGE_MEAS[k]) send_measurement(EDGE_MEAS[k]);
        drain_results();

        // Random part: one settings draw per phase, cycling through the idle mixes.
        walk = '0;
        for (int p = 0; p < 10; p++) begin
            cfg = random_settings();
            apply_settings(cfg);
            set_idle_mode(p % 4);
            walk = cfg.target;
            for (int i = 0; i < 110; i++) begin
                if (p == 2 && i == 30) begin
                    // Long output stall while the sender keeps pushing.
                    hold_cycles = 250;
                end
                if (p == 5 && i == 55) begin
                    drain_results();
                end
                walk = pick_measurement(walk);
                send_measurement(walk);
            end
            drain_results();
        end

        // Let any stray result surface before the verdict.
        set_idle_mode(0);
        repeat (8) @(posedge aclk);
        errors = tracker.mismatches + tracker.pending();
        if (tracker.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, tracker.pending());
        end

        $display("Checked %0d drive values over %0d register settings and four idle mixes,",
                 tracker.checked, settings_applied);
        $display("with %0d inside the limits, %0d clamped high and %0d clamped low.",
                 tracker.clamp_seen[0], tracker.clamp_seen[1], tracker.clamp_seen[2]);
        if (errors == 0) begin
            $display("** pid_dom_antiwindup_core: PASSED **");
        end else begin
            $display("** pid_dom_antiwindup_core: FAILED **");
        end
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial begin
        #5_000_000;
        $display("** pid_dom_antiwindup_core: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/pid_dom_pkg.sv
src/pid_dom_cfg.sv
src/pid_dom_prod.sv
src/pid_dom_acc.sv
src/pid_dom_antiwindup_core.sv
src/pid_dom_chk.sv
tb/sv/tb.sv
